// ===== sv/hev_pkg.sv =====
// Package for the hostname / email validator: shared types, constants and
// register indexes. No dependencies.
package hev_pkg;

   // Character class of the previous byte
   typedef enum logic [1:0] {
      KIND_OTHER  = 2'd0,
      KIND_HYPHEN = 2'd1,
      KIND_DOT    = 2'd2
   } kind_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MODE      = 2'd0,
      CSR_MAX_LABEL = 2'd1,
      CSR_MAX_TOTAL = 2'd2,
      CSR_MAX_LOCAL = 2'd3
   } csr_index_type;

   localparam logic       MODE_HOST  = 1'b0;
   localparam logic       MODE_EMAIL = 1'b1;

   localparam logic [7:0] CHAR_AT     = 8'h40;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   localparam logic [5:0] MAX_LABEL_RESET = 6'd63;
   localparam logic [7:0] MAX_TOTAL_RESET = 8'd253;
   localparam logic [5:0] MAX_LOCAL_RESET = 6'd63;
   localparam logic [7:0] TOTAL_SAT       = 8'd255;

   // Configuration registers
   typedef struct packed {
      logic       mode;
      logic [5:0] max_label;
      logic [7:0] max_total;
      logic [5:0] max_local;
   } cfg_type;

   // Per-string scan state
   typedef struct packed {
      logic       failed;
      logic       in_domain;
      logic       at_part_start;
      kind_type   prev_kind;
      logic [5:0] label_count;
      logic [7:0] total_count;
      logic [5:0] local_count;
   } scan_type;

   localparam scan_type SCAN_RESET = '{
      failed:        1'b0,
      in_domain:     1'b0,
      at_part_start: 1'b1,
      prev_kind:     KIND_OTHER,
      label_count:   6'd0,
      total_count:   8'd0,
      local_count:   6'd0
   };

   localparam cfg_type CFG_RESET = '{
      mode:      MODE_HOST,
      max_label: MAX_LABEL_RESET,
      max_total: MAX_TOTAL_RESET,
      max_local: MAX_LOCAL_RESET
   };

   function automatic logic letter_or_digit(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
             (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic kind_type kind_of(input logic [7:0] b);
      kind_type k;
      k = KIND_OTHER;
      if (b == CHAR_HYPHEN) k = KIND_HYPHEN;
      else if (b == CHAR_DOT) k = KIND_DOT;
      return k;
   endfunction

endpackage

// ===== sv/hev_step.sv =====
// Per-byte scan logic: next scan state and verdict for one byte.
// Depends on hev_pkg.
module hev_step (
   input  hev_pkg::cfg_type  cfg,
   input  hev_pkg::scan_type cur,
   input  logic [7:0]        text_byte,
   input  logic              last,
   output hev_pkg::scan_type nxt,
   output logic              verdict
);
   import hev_pkg::*;

   scan_type upd;
   kind_type k;
   logic     alnum;

   // Apply one byte to the scan state
   always_comb begin
      k     = kind_of(text_byte);
      alnum = letter_or_digit(text_byte);
      upd   = cur;
      if (!cur.failed) begin
         if (cfg.mode == MODE_HOST || cur.in_domain) begin
            // hostname label rules
            if (cur.at_part_start && !alnum) begin
               upd.failed = 1'b1;
            end else if (k != KIND_OTHER && cur.prev_kind != KIND_OTHER) begin
               upd.at_part_start = 1'b0;
               upd.failed        = 1'b1;
            end else if (k == KIND_HYPHEN || alnum) begin
               upd.at_part_start = 1'b0;
               if (cur.label_count >= cfg.max_label ||
                   cur.total_count >= cfg.max_total) begin
                  upd.failed = 1'b1;
               end else begin
                  upd.label_count = cur.label_count + 6'd1;
                  if (cur.total_count != TOTAL_SAT)
                     upd.total_count = cur.total_count + 8'd1;
                  upd.prev_kind = k;
               end
            end else if (k == KIND_DOT) begin
               upd.at_part_start = 1'b0;
               upd.label_count   = 6'd0;
               if (cur.total_count != TOTAL_SAT)
                  upd.total_count = cur.total_count + 8'd1;
               upd.prev_kind = k;
            end else begin
               upd.at_part_start = 1'b0;
               upd.failed        = 1'b1;
            end
         end else begin
            // email local part
            if (cur.at_part_start && (text_byte == CHAR_SPACE ||
                text_byte == CHAR_DOT || text_byte == CHAR_AT)) begin
               upd.failed = 1'b1;
            end else if (text_byte == CHAR_AT) begin
               if (cur.prev_kind == KIND_DOT) begin
                  upd.at_part_start = 1'b0;
                  upd.failed        = 1'b1;
               end else begin
                  upd.in_domain     = 1'b1;
                  upd.at_part_start = 1'b1;
                  upd.prev_kind     = KIND_OTHER;
                  upd.label_count   = 6'd0;
                  upd.total_count   = 8'd0;
               end
            end else begin
               upd.at_part_start = 1'b0;
               if (text_byte[7:6] != 2'b10) begin
                  if (cur.local_count >= cfg.max_local) begin
                     upd.failed = 1'b1;
                  end else begin
                     upd.local_count = cur.local_count + 6'd1;
                     upd.prev_kind   = k;
                  end
               end else begin
                  upd.prev_kind = k;
               end
            end
         end
      end
   end

   // Verdict on the final byte, then clear for the next string
   always_comb begin
      if (upd.failed) verdict = 1'b0;
      else if (cfg.mode == MODE_HOST) verdict = (upd.prev_kind != KIND_HYPHEN);
      else verdict = upd.in_domain && !upd.at_part_start &&
                     (upd.prev_kind == KIND_OTHER);
      nxt = last ? SCAN_RESET : upd;
   end

endmodule

// ===== sv/hostname_email_validator.sv =====
// Request beats pass through the input register; verdicts leave from the response register.
// Throughput: one byte per cycle; a string's verdict comes out on its last byte.
// The input register is the only stall point: it holds a last byte only while
// the response register is full and stalled.
// Synchronous active-high reset restores the register defaults and clears the
// scan state and the valid flags of both pipeline registers.
// Top level of the validator. Depends on hev_pkg and hev_step.
module hostname_email_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import hev_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   scan_type   scan_ff, scan_in, scan_nxt;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_res_ff, out_res_in;
   logic       verdict;
   logic       out_free, s1_fire, req_fire;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:      cfg_in.mode      = csr_wdata[0];
            CSR_MAX_LABEL: cfg_in.max_label = csr_wdata[5:0];
            CSR_MAX_TOTAL: cfg_in.max_total = csr_wdata;
            CSR_MAX_LOCAL: cfg_in.max_local = csr_wdata[5:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Handshake between input register and response register
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_fire  = req_valid && !req_stall;

   hev_step u_step (
      .cfg       (cfg_ff),
      .cur       (scan_ff),
      .text_byte (s1_byte_ff),
      .last      (s1_last_ff),
      .nxt       (scan_nxt),
      .verdict   (verdict)
   );

   // Next values of the pipeline and scan state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      s1_last_in   = s1_last_ff;
      scan_in      = scan_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
         scan_in     = scan_nxt;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_text_byte;
         s1_last_in  = req_last;
      end
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (s1_fire && s1_last_ff) begin
         out_valid_in = 1'b1;
         out_res_in   = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         scan_ff      <= SCAN_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         scan_ff      <= scan_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_valid_res = out_res_ff;

   // An empty input register never stalls the request side
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with empty input register");

   // A last byte leaves the scan state at its reset value
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> scan_ff == SCAN_RESET)
      else $error("scan state not cleared after last byte");

   // A last byte always produces a response beat
   a_rsp_on_last: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> out_valid_ff)
      else $error("last byte without response");

   // At the start of a part the previous kind is always neutral
   a_part_start_kind: assert property (@(posedge clock) disable iff (reset)
      !scan_ff.failed && scan_ff.at_part_start |-> scan_ff.prev_kind == KIND_OTHER)
      else $error("part start with stale previous kind");

endmodule

// ===== sim/tb_hostname_email_validator.sv =====
// Self-checking testbench for hostname_email_validator: directed strings, then random
// hostnames and email addresses under changing register settings and idle patterns.
// Depends on hev_pkg and the validator RTL.
module tb_hostname_email_validator;
   timeunit 1ns;
   timeprecision 1ps;

   import hev_pkg::*;

   typedef logic [7:0] text_t[$];

   // Tracks the per-string scan state and holds the verdicts still to come
   class verdict_scoreboard;
      logic       mode;
      logic [5:0] max_label;
      logic [7:0] max_total;
      logic [5:0] max_local;
      bit         broken;
      bit         after_at;
      bit         part_start;
      kind_type   prev_kind;
      logic [5:0] label_len;
      logic [7:0] host_len;
      logic [5:0] local_len;
      logic       expected_verdicts[$];
      int         errors;
      int         checked;
      int         n_accept;
      int         n_reject;

      function new();
         mode      = MODE_HOST;
         max_label = MAX_LABEL_RESET;
         max_total = MAX_TOTAL_RESET;
         max_local = MAX_LOCAL_RESET;
         errors    = 0;
         checked   = 0;
         n_accept  = 0;
         n_reject  = 0;
         restart();
      endfunction

      function void restart();
         broken     = 1'b0;
         after_at   = 1'b0;
         part_start = 1'b1;
         prev_kind  = KIND_OTHER;
         label_len  = '0;
         host_len   = '0;
         local_len  = '0;
      endfunction

      function bit alnum_char(logic [7:0] b);
         return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      endfunction

      function kind_type char_kind(logic [7:0] b);
         if (b == CHAR_HYPHEN) return KIND_HYPHEN;
         if (b == CHAR_DOT) return KIND_DOT;
         return KIND_OTHER;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] data);
         case (idx)
            CSR_MODE:      mode = data[0];
            CSR_MAX_LABEL: max_label = data[5:0];
            CSR_MAX_TOTAL: max_total = data;
            CSR_MAX_LOCAL: max_local = data[5:0];
            default: ;
         endcase
      endfunction

      // Hostname rules, also used for the domain of an email address
      function void host_char(logic [7:0] b);
         kind_type k;
         bit       an;
         k  = char_kind(b);
         an = alnum_char(b);
         if (part_start && !an) begin
            broken = 1'b1;
            return;
         end
         part_start = 1'b0;
         if (k != KIND_OTHER && prev_kind != KIND_OTHER) begin
            broken = 1'b1;
            return;
         end
         if (k == KIND_HYPHEN || an) begin
            if (label_len >= max_label || host_len >= max_total) begin
               broken = 1'b1;
               return;
            end
            label_len++;
         end else if (k == KIND_DOT) begin
            label_len = '0;
         end else begin
            broken = 1'b1;
            return;
         end
         if (host_len != TOTAL_SAT) host_len++;
         prev_kind = k;
      endfunction

      // Email local part: continuation bytes are not counted
      function void local_char(logic [7:0] b);
         if (part_start) begin
            if (b == CHAR_SPACE || b == CHAR_DOT || b == CHAR_AT) begin
               broken = 1'b1;
               return;
            end
            part_start = 1'b0;
         end
         if (b == CHAR_AT) begin
            if (prev_kind == KIND_DOT) begin
               broken = 1'b1;
               return;
            end
            after_at   = 1'b1;
            part_start = 1'b1;
            prev_kind  = KIND_OTHER;
            label_len  = '0;
            host_len   = '0;
            return;
         end
         if (b[7:6] != 2'b10) begin
            if (local_len >= max_local) begin
               broken = 1'b1;
               return;
            end
            local_len++;
         end
         prev_kind = char_kind(b);
      endfunction

      function void note_beat(logic [7:0] b, logic is_last);
         logic ok;
         if (!broken) begin
            if (mode == MODE_HOST || after_at) host_char(b);
            else local_char(b);
         end
         if (is_last) begin
            ok = !broken;
            if (ok) begin
               if (mode == MODE_HOST) ok = (prev_kind != KIND_HYPHEN);
               else ok = after_at && !part_start && prev_kind == KIND_OTHER;
            end
            expected_verdicts.push_back(ok);
            restart();
         end
      endfunction

      function void flag(string what, logic want, logic got);
         errors++;
         if (errors <= 10)
            $display("%0t: %s: expected %b, got %b", $realtime, what, want, got);
      endfunction

      function void check_verdict(logic got);
         logic want;
         checked++;
         if (got) n_accept++;
         else n_reject++;
         if (expected_verdicts.size() == 0) begin
            flag("verdict with none pending", 1'bx, got);
            return;
         end
         want = expected_verdicts.pop_front();
         if (got !== want) flag("verdict mismatch", want, got);
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h01;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_valid_res;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_MODE;
   logic [7:0] csr_wdata = 8'h00;

   verdict_scoreboard sb = new();

   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         beats_sent = 0;
   int         strings_sent = 0;
   int         settings = 1;
   logic       cur_mode = MODE_HOST;
   int         cur_label = int'(MAX_LABEL_RESET);
   int         cur_local = int'(MAX_LOCAL_RESET);

   hostname_email_validator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   // Random receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watch both channels: accepted beats feed the scoreboard, verdicts are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_beat(req_text_byte, req_last);
            beats_sent++;
            if (req_last) strings_sent++;
         end
         if (rsp_valid && !rsp_stall) sb.check_verdict(rsp_valid_res);
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [7:0] rand_alnum();
      int k;
      k = $urandom_range(61);
      if (k < 10) return 8'("0" + k);
      if (k < 36) return 8'("a" + k - 10);
      return 8'("A" + k - 36);
   endfunction

   // Dotted labels, mostly short, sometimes at or one past the label limit
   function automatic text_t make_host(input int lab_max);
      text_t t;
      int    labels;
      int    len;
      labels = $urandom_range(1, 4);
      for (int i = 0; i < labels; i++) begin
         if (i > 0) t.push_back(CHAR_DOT);
         len = ($urandom_range(9) == 0) ? lab_max + $urandom_range(1) : $urandom_range(1, 6);
         if (len < 1) len = 1;
         for (int j = 0; j < len; j++) begin
            if (j > 0 && j < len - 1 && $urandom_range(7) == 0) t.push_back(CHAR_HYPHEN);
            else t.push_back(rand_alnum());
         end
      end
      case ($urandom_range(19))
         0: t.push_back(CHAR_HYPHEN);
         1: t.push_back(CHAR_DOT);
         default: ;
      endcase
      return t;
   endfunction

   // Local part with dots, hyphens, spaces and two-byte UTF-8 characters
   function automatic text_t make_local(input int loc_max);
      text_t t;
      int    len;
      int    r;
      len = ($urandom_range(9) == 0) ? loc_max + $urandom_range(1) : $urandom_range(1, 6);
      if (len < 1) len = 1;
      for (int j = 0; j < len; j++) begin
         r = $urandom_range(19);
         if (r < 12) t.push_back(rand_alnum());
         else if (r < 14 && j > 0) t.push_back(CHAR_DOT);
         else if (r < 15) t.push_back(CHAR_HYPHEN);
         else if (r < 17) begin
            t.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            t.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end else if (r < 18 && j > 0) t.push_back(CHAR_SPACE);
         else t.push_back("_");
      end
      return t;
   endfunction

   // Mostly well-formed strings, some pure noise, some with one byte corrupted
   function automatic text_t make_text(input bit email, input int lab_max, input int loc_max);
      text_t t;
      text_t dom;
      int    r;
      int    n;
      r = $urandom_range(99);
      if ($urandom_range(15) == 0) email = !email;
      if (r >= 80 && r < 90) begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(1, 255)));
      end else begin
         if (email) begin
            t = make_local(loc_max);
            if ($urandom_range(19) != 0) t.push_back(CHAR_AT);
            dom = make_host(lab_max);
            foreach (dom[i]) t.push_back(dom[i]);
         end else begin
            t = make_host(lab_max);
         end
         if (r >= 90) t[$urandom_range(t.size() - 1)] = 8'($urandom_range(1, 255));
      end
      return t;
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last      <= is_last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text(input text_t t);
      foreach (t[i]) send_beat(t[i], i == t.size() - 1);
   endtask

   task automatic send_string(input string s);
      text_t t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      send_text(t);
   endtask

   // Hold the sender until every verdict is back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_beat(input csr_index_type idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   // Write all four registers; unused upper bits carry junk
   task automatic set_config(input logic m, input logic [5:0] lab, input logic [7:0] tot,
                             input logic [5:0] loc);
      csr_beat(CSR_MODE, {7'($urandom), m});
      csr_beat(CSR_MAX_LABEL, {2'($urandom), lab});
      csr_beat(CSR_MAX_TOTAL, tot);
      csr_beat(CSR_MAX_LOCAL, {2'($urandom), loc});
      csr_valid <= 1'b0;
      cur_mode  = m;
      cur_label = int'(lab);
      cur_local = int'(loc);
      settings++;
   endtask

   initial begin
      text_t      t;
      logic       m;
      logic [5:0] lab;
      logic [7:0] tot;
      logic [5:0] loc;
      int         target;
      int         n;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed hostnames at reset settings
      send_idle_pct = 23;
      recv_idle_pct = 82;
      send_string("Z9");
      send_string("a-");
      send_string("a..");
      send_string("\377");
      drain();

      // Directed email addresses: bare at, no at, empty domain, UTF-8, trailing dots
      set_config(MODE_EMAIL, MAX_LABEL_RESET, MAX_TOTAL_RESET, MAX_LOCAL_RESET);
      send_string("@");
      send_string("\001");
      send_string("x@");
      send_string("\303\251@a");
      send_string("x.@a");
      send_string("x@a.");
      drain();

      // Random phases: three idle patterns, four settings each
      for (int p = 0; p < 12; p++) begin
         send_idle_pct = (p < 4) ? 23 : (p < 8) ? 82 : 0;
         recv_idle_pct = (p < 4) ? 82 : (p < 8) ? 23 : 0;
         case (p)
            0: begin m = MODE_HOST;  lab = 6'd63; tot = 8'd255; loc = 6'd63; end
            1: begin m = MODE_EMAIL; lab = 6'd1;  tot = 8'd1;   loc = 6'd1;  end
            2: begin m = MODE_HOST;  lab = 6'd0;  tot = 8'd0;   loc = 6'd0;  end
            3: begin m = MODE_EMAIL; lab = 6'd0;  tot = 8'd0;   loc = 6'd0;  end
            4: begin m = MODE_EMAIL; lab = 6'd63; tot = 8'd253; loc = 6'd63; end
            default: begin
               m   = p[0] ? MODE_EMAIL : MODE_HOST;
               lab = $urandom_range(1) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(63));
               tot = $urandom_range(1) ? 8'($urandom_range(1, 24)) : 8'($urandom_range(255));
               loc = $urandom_range(1) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(63));
            end
         endcase
         set_config(m, lab, tot, loc);
         target = beats_sent + 95;

         // Full-length labels that run past the total limit and saturate the count
         if (p == 0) begin
            t.delete();
            for (int i = 0; i < 5; i++) begin
               if (i > 0) t.push_back(CHAR_DOT);
               for (int j = 0; j < 63; j++) t.push_back(rand_alnum());
            end
            send_text(t);
         end

         while (beats_sent < target)
            send_text(make_text(cur_mode == MODE_EMAIL, cur_label, cur_local));

         // Leave a string open so the next settings apply mid-string
         if (p < 11 && $urandom_range(1)) begin
            t = make_text(cur_mode == MODE_EMAIL, cur_label, cur_local);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n && i < t.size() - 1; i++) send_beat(t[i], 1'b0);
         end
         drain();
      end

      $display("covered %0d bytes in %0d strings over %0d register settings, both modes",
               beats_sent, strings_sent, settings);
      $display("%0d verdicts compared: %0d accepted, %0d rejected",
               sb.checked, sb.n_accept, sb.n_reject);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/hev_pkg.sv
sv/hev_step.sv
sv/hostname_email_validator.sv
sim/tb_hostname_email_validator.sv
